// ----- rtl/pps_counter_timestamp_corrector_top_macros.svh -----
// ----------------------------------------------------------------------------
// PPS timestamp corrector assertion macros
// Implication checks, same-cycle and next-cycle, shared by the RTL files.
// ----------------------------------------------------------------------------
`ifndef PPS_COUNTER_TIMESTAMP_CORRECTOR_TOP_MACROS_SVH
`define PPS_COUNTER_TIMESTAMP_CORRECTOR_TOP_MACROS_SVH

`ifndef NO_ASSERTIONS

`define PCTC_ASSERT_IMP(name, clk, rst, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("pctc: same-cycle check failed");

`define PCTC_ASSERT_NXT(name, clk, rst, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("pctc: next-cycle check failed");

`else

`define PCTC_ASSERT_IMP(name, clk, rst, ante, cons)

`define PCTC_ASSERT_NXT(name, clk, rst, ante, cons)

`endif

`endif

// ----- rtl/pctc_pkg.sv -----
// ----------------------------------------------------------------------------
// PPS timestamp corrector package
// Shared types and constants.
// ----------------------------------------------------------------------------
package pctc_pkg;

  typedef struct packed {
    logic [30:0] count_ns;
    logic [30:0] host_sec;
    logic [29:0] host_nsec;
  } sample_t;

  localparam logic [30:0] GEN2_COUNT_MAX = 31'd1398080000;
  localparam logic [30:0] GEN3_COUNT_MAX = 31'd1048560000;
  // floor(max * 0.96)
  localparam logic [30:0] GEN2_THRESH    = 31'd1342156800;
  localparam logic [30:0] GEN3_THRESH    = 31'd1006617600;

  localparam logic [29:0] HALF_SEC_NS    = 30'd500000000;

  localparam logic [32:0] SEC_X1 = 33'd1000000000;
  localparam logic [32:0] SEC_X2 = 33'd2000000000;
  localparam logic [32:0] SEC_X3 = 33'd3000000000;
  localparam logic [32:0] SEC_X4 = 33'd4000000000;

  localparam logic signed [30:0] NSEC_LIM_P = 31'sd1000000000;
  localparam logic signed [30:0] NSEC_LIM_N = -31'sd1000000000;

endpackage

// ----- rtl/pctc_sec_mod.sv -----
// ----------------------------------------------------------------------------
// PPS timestamp corrector one-second remainder
// Truncated (sign keeping) remainder of a 34-bit sum by 1e9.
// ----------------------------------------------------------------------------
module pctc_sec_mod (
  input  logic signed [33:0] sum,
  output logic signed [30:0] nsec
);
  import pctc_pkg::*;

  logic        neg;
  logic [33:0] mag_full;
  logic [32:0] mag;
  logic [32:0] rem;
  logic [29:0] rem_lo;

  assign neg      = sum[33];
  assign mag_full = neg ? 34'(-sum) : sum;
  assign mag      = mag_full[32:0];

  // |sum| stays below 2^32, so at most four seconds come off
  always_comb begin
    if (mag >= SEC_X4) begin
      rem = mag - SEC_X4;
    end else if (mag >= SEC_X3) begin
      rem = mag - SEC_X3;
    end else if (mag >= SEC_X2) begin
      rem = mag - SEC_X2;
    end else if (mag >= SEC_X1) begin
      rem = mag - SEC_X1;
    end else begin
      rem = mag;
    end
  end

  assign rem_lo = rem[29:0];
  assign nsec   = neg ? 31'(-{1'b0, rem_lo}) : {1'b0, rem_lo};

endmodule

// ----- rtl/pctc_core.sv -----
`include "pps_counter_timestamp_corrector_top_macros.svh"
// ----------------------------------------------------------------------------
// PPS timestamp corrector core
// Counter tracking state, nanosecond accumulation and seconds correction.
// ----------------------------------------------------------------------------
module pctc_core (
  input  logic              clk,
  input  logic              rst,
  input  logic              cfg_wen,
  input  logic              cfg_wdata,
  input  logic              fire,
  input  pctc_pkg::sample_t sample,
  output logic [31:0]       stamp_sec_next,
  output logic [30:0]       stamp_nsec_next
);
  import pctc_pkg::*;

  logic              counter_gen2;
  logic [30:0]       last_count;
  logic signed [30:0] accum_nsec;
  logic signed [30:0] last_accum_nsec;
  logic [31:0]       last_stamp_sec;
  logic              near_wrap_flag;
  logic              sensor_leads_flag;

  logic [30:0]       cmax;
  logic [30:0]       thresh;
  logic              above;
  logic [32:0]       delta;
  logic              dec;
  logic [32:0]       wrap_moved;
  logic signed [32:0] moved;
  logic              pps_reset;
  logic signed [30:0] accum_base;
  logic signed [33:0] sum;
  logic signed [30:0] accum_next;
  logic              near_wrap_next;
  logic [31:0]       host_ext;
  logic              host_late;
  logic              nsec_up;
  logic [31:0]       accum_diff;
  logic              cond_dec;
  logic              cond_inc;
  logic              cond_hold;
  logic              leads_next;

  assign cmax   = counter_gen2 ? GEN2_COUNT_MAX : GEN3_COUNT_MAX;
  assign thresh = counter_gen2 ? GEN2_THRESH : GEN3_THRESH;
  assign above  = sample.count_ns > thresh;

  assign delta      = {2'b00, sample.count_ns} - {2'b00, last_count};
  assign dec        = delta[32];
  assign wrap_moved = {2'b00, sample.count_ns} + {2'b00, cmax} - {2'b00, last_count};
  assign pps_reset  = !above && dec && !near_wrap_flag;

  always_comb begin
    if (!above && dec) begin
      moved = near_wrap_flag ? $signed(wrap_moved) : $signed({2'b00, sample.count_ns});
    end else begin
      moved = $signed(delta);
    end
  end

  assign accum_base     = pps_reset ? '0 : accum_nsec;
  assign sum            = 34'(accum_base) + 34'(moved);
  assign near_wrap_next = above ? 1'b1 : (dec ? 1'b0 : near_wrap_flag);

  pctc_sec_mod u_sec_mod (
    .sum  (sum),
    .nsec (accum_next)
  );

  assign host_ext   = {1'b0, sample.host_sec};
  assign host_late  = sample.host_nsec > HALF_SEC_NS;
  assign nsec_up    = !accum_next[30] && (accum_next[29:0] > HALF_SEC_NS);
  assign accum_diff = 32'(accum_next) - 32'(last_accum_nsec);

  assign cond_dec  = (host_ext != last_stamp_sec) && nsec_up;
  assign cond_inc  = accum_diff[31] && host_late;
  assign cond_hold = sensor_leads_flag && host_late;

  always_comb begin
    if (cond_dec) begin
      stamp_sec_next = host_ext - 32'd1;
      leads_next     = sensor_leads_flag;
    end else if (cond_inc || cond_hold) begin
      stamp_sec_next = host_ext + 32'd1;
      leads_next     = 1'b1;
    end else begin
      stamp_sec_next = host_ext;
      leads_next     = 1'b0;
    end
  end

  assign stamp_nsec_next = accum_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      counter_gen2      <= 1'b0;
      last_count        <= '0;
      accum_nsec        <= '0;
      last_accum_nsec   <= '0;
      last_stamp_sec    <= '0;
      near_wrap_flag    <= 1'b0;
      sensor_leads_flag <= 1'b0;
    end else begin
      if (cfg_wen) begin
        counter_gen2 <= cfg_wdata;
      end
      if (fire) begin
        last_count        <= sample.count_ns;
        accum_nsec        <= accum_next;
        last_accum_nsec   <= accum_next;
        last_stamp_sec    <= stamp_sec_next;
        near_wrap_flag    <= near_wrap_next;
        sensor_leads_flag <= leads_next;
      end
    end
  end

  `PCTC_ASSERT_IMP(a_accum_range, clk, rst, 1'b1, ($signed(accum_nsec) < NSEC_LIM_P) && ($signed(accum_nsec) > NSEC_LIM_N))
  `PCTC_ASSERT_NXT(a_near_set, clk, rst, fire && above, near_wrap_flag)
  `PCTC_ASSERT_NXT(a_near_clear, clk, rst, fire && !above && dec, !near_wrap_flag)

endmodule

// ----- rtl/pps_counter_timestamp_corrector_top.sv -----
`include "pps_counter_timestamp_corrector_top_macros.svh"
// ----------------------------------------------------------------------------
// PPS counter timestamp corrector
// Takes one sample beat per cycle while sample_stall is low (counter value in
// ns since the last PPS plus host seconds and nanoseconds) and returns one
// corrected timestamp beat for each. A beat is held in an input register, and
// the correction runs in a single pass of logic from there into the result
// register, so a new sample can be taken every cycle unless the output stalls;
// the limit is the loop through the counter and accumulator state. counter_gen2
// selects the counter maximum and may be written only while no beat is in
// flight.
// ----------------------------------------------------------------------------
module pps_counter_timestamp_corrector_top (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_wen,
  input  logic        cfg_wdata,
  input  logic        sample_valid,
  output logic        sample_stall,
  input  logic [30:0] count_ns,
  input  logic [30:0] host_sec,
  input  logic [29:0] host_nsec,
  output logic        stamp_valid,
  input  logic        stamp_stall,
  output logic [31:0] stamp_sec,
  output logic [30:0] stamp_nsec
);
  import pctc_pkg::*;

  logic        s0_valid;
  sample_t     s0;
  logic        adv;
  logic        take;
  logic [31:0] stamp_sec_next;
  logic [30:0] stamp_nsec_next;
  logic [31:0] s0_host_ext;

  assign adv          = s0_valid && (!stamp_valid || !stamp_stall);
  assign sample_stall = s0_valid && !adv;
  assign take         = sample_valid && !sample_stall;
  assign s0_host_ext  = {1'b0, s0.host_sec};

  always_ff @(posedge clk) begin
    if (rst) begin
      s0_valid <= 1'b0;
    end else if (take) begin
      s0_valid <= 1'b1;
    end else if (adv) begin
      s0_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      s0.count_ns  <= count_ns;
      s0.host_sec  <= host_sec;
      s0.host_nsec <= host_nsec;
    end
  end

  pctc_core u_core (
    .clk             (clk),
    .rst             (rst),
    .cfg_wen         (cfg_wen),
    .cfg_wdata       (cfg_wdata),
    .fire            (adv),
    .sample          (s0),
    .stamp_sec_next  (stamp_sec_next),
    .stamp_nsec_next (stamp_nsec_next)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      stamp_valid <= 1'b0;
    end else if (adv) begin
      stamp_valid <= 1'b1;
    end else if (!stamp_stall) begin
      stamp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      stamp_sec  <= stamp_sec_next;
      stamp_nsec <= stamp_nsec_next;
    end
  end

  `PCTC_ASSERT_NXT(a_adv_out, clk, rst, adv, stamp_valid)
  `PCTC_ASSERT_NXT(a_sec_window, clk, rst, adv, (stamp_sec == $past(s0_host_ext)) || (stamp_sec == $past(s0_host_ext) + 32'd1) || (stamp_sec == $past(s0_host_ext) - 32'd1))

endmodule
